@@ rtl/tbn_pkg.sv @@
// shared constants and command type for the triangle tangent/binormal unit
`timescale 1ns / 1ps
package tbn_pkg;

    localparam int POS_W        = 32;
    localparam int UV_W         = 19;
    localparam int UV_FRAC_BITS = 16;
    localparam int TRI_W        = 24;

    localparam int DP_W   = POS_W + 1;         // position delta
    localparam int DU_W   = UV_W + 1;          // texcoord delta
    localparam int PROD_W = DP_W + DU_W;       // one product
    localparam int NUM_W  = PROD_W + 1;        // difference of two products
    localparam int DET_W  = 2 * DU_W + 1;      // uv determinant
    localparam int QB     = 34;                // quotient bits incl. rounding bit
    localparam int LO_W   = QB - UV_FRAC_BITS - 1;
    localparam int HI_W   = NUM_W - LO_W;
    localparam int REM_W  = DET_W + 1;

    localparam int NTERM     = 7;              // determinant plus six numerators
    localparam int LANES     = 6;
    localparam int MUL_STEPS = 2 * NTERM;
    localparam int STEP_W    = $clog2(MUL_STEPS);
    localparam int TERM_W    = $clog2(NTERM);
    localparam int CNT_W     = $clog2(QB + 1);

    localparam logic [1:0] SLOT_LAST = 2'd2;

    typedef struct packed {
        logic              load;
        logic [1:0]        slot;
        logic              mul_en;
        logic [STEP_W-1:0] mul_step;
        logic              div_start;
        logic              div_step;
        logic              out_load;
    } tbn_cmd_t;

endpackage

@@ rtl/tbn_ctrl.sv @@
// sequencer: vertex slots, multiply pass, divide pass, result hand-off
`timescale 1ns / 1ps
module tbn_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output tbn_pkg::tbn_cmd_t cmd
);
    import tbn_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t           state_reg;
    logic [1:0]       slot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             m_valid_reg;
    logic             accept;
    logic             out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd           = '0;
        cmd.load      = accept;
        cmd.slot      = slot_reg;
        cmd.mul_en    = (state_reg == ST_MUL) && (cnt_reg < CNT_W'(MUL_STEPS));
        cmd.mul_step  = cnt_reg[STEP_W-1:0];
        cmd.div_start = (state_reg == ST_DIV_INIT);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.out_load  = (state_reg == ST_OUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= 2'd0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (slot_reg == SLOT_LAST) begin
                            slot_reg  <= 2'd0;
                            cnt_reg   <= '0;
                            state_reg <= ST_MUL;
                        end else begin
                            slot_reg <= slot_reg + 2'd1;
                        end
                    end
                end
                ST_MUL: begin
                    // the final count, past the last step, drains the product register
                    if (cnt_reg == CNT_W'(MUL_STEPS)) begin
                        state_reg <= ST_DIV_INIT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIV_INIT: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (cnt_reg == CNT_W'(QB - 1)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/tbn_datapath.sv @@
// vertex store, shared multiplier, six restoring divider lanes, output register
`timescale 1ns / 1ps
module tbn_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tbn_pkg::tbn_cmd_t                   cmd,
    input  logic signed [tbn_pkg::POS_W-1:0]    s_pos_x,
    input  logic signed [tbn_pkg::POS_W-1:0]    s_pos_y,
    input  logic signed [tbn_pkg::POS_W-1:0]    s_pos_z,
    input  logic signed [tbn_pkg::UV_W-1:0]     s_tex_u,
    input  logic signed [tbn_pkg::UV_W-1:0]     s_tex_v,
    output logic signed [tbn_pkg::POS_W-1:0]    m_tangent_x,
    output logic signed [tbn_pkg::POS_W-1:0]    m_tangent_y,
    output logic signed [tbn_pkg::POS_W-1:0]    m_tangent_z,
    output logic signed [tbn_pkg::POS_W-1:0]    m_binormal_x,
    output logic signed [tbn_pkg::POS_W-1:0]    m_binormal_y,
    output logic signed [tbn_pkg::POS_W-1:0]    m_binormal_z,
    output logic        [tbn_pkg::TRI_W-1:0]    m_triangle_number,
    output logic                                m_degenerate
);
    import tbn_pkg::*;

    logic signed [POS_W-1:0] pos_reg [2][3];
    logic signed [UV_W-1:0]  uv_reg  [2][2];
    logic signed [POS_W-1:0] p_in [3];

    logic signed [DP_W-1:0]  dp1_reg [3];
    logic signed [DP_W-1:0]  dp2_reg [3];
    logic signed [DU_W-1:0]  du1u_reg, du1v_reg, du2u_reg, du2v_reg;

    logic signed [DP_W-1:0]   op_a;
    logic signed [DU_W-1:0]   op_b;
    logic        [STEP_W-1:0] sm2;
    logic        [1:0]        lane_sel;
    logic signed [DP_W-1:0]   dp1_sel, dp2_sel;
    logic signed [PROD_W-1:0] prod_reg, first_reg;
    logic        [STEP_W-1:0] step_d_reg;
    logic                     pv_reg;
    logic signed [NUM_W-1:0]  term_reg [NTERM];

    logic signed [DET_W-1:0]  det;
    logic        [DET_W-1:0]  dmag_reg;
    logic                     det_zero_reg;

    logic [REM_W-1:0] rem_reg [LANES];
    logic [QB-1:0]    lo_reg  [LANES];
    logic [QB-1:0]    q_reg   [LANES];
    logic             neg_reg [LANES];
    logic             ovf_reg [LANES];
    logic signed [POS_W-1:0] res [LANES];

    logic signed [POS_W-1:0] tan_reg [3];
    logic signed [POS_W-1:0] bin_reg [3];
    logic [TRI_W-1:0]        tri_reg;
    logic                    degen_reg;

    assign p_in[0] = s_pos_x;
    assign p_in[1] = s_pos_y;
    assign p_in[2] = s_pos_z;

    // vertex capture and edge deltas
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (cmd.slot != SLOT_LAST) begin
                for (int i = 0; i < 3; i++) begin
                    pos_reg[cmd.slot[0]][i] <= p_in[i];
                end
                uv_reg[cmd.slot[0]][0] <= s_tex_u;
                uv_reg[cmd.slot[0]][1] <= s_tex_v;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    dp1_reg[i] <= DP_W'(pos_reg[1][i]) - DP_W'(pos_reg[0][i]);
                    dp2_reg[i] <= DP_W'(p_in[i]) - DP_W'(pos_reg[0][i]);
                end
                du1u_reg <= DU_W'(uv_reg[1][0]) - DU_W'(uv_reg[0][0]);
                du1v_reg <= DU_W'(uv_reg[1][1]) - DU_W'(uv_reg[0][1]);
                du2u_reg <= DU_W'(s_tex_u) - DU_W'(uv_reg[0][0]);
                du2v_reg <= DU_W'(s_tex_v) - DU_W'(uv_reg[0][1]);
            end
        end
    end

    // operand selection: det terms first, then binormal/tangent per axis
    assign sm2      = cmd.mul_step - STEP_W'(2);
    assign lane_sel = sm2[3:2];

    always_comb begin
        case (lane_sel)
            2'd1:    begin dp1_sel = dp1_reg[1]; dp2_sel = dp2_reg[1]; end
            2'd2:    begin dp1_sel = dp1_reg[2]; dp2_sel = dp2_reg[2]; end
            default: begin dp1_sel = dp1_reg[0]; dp2_sel = dp2_reg[0]; end
        endcase
        if (cmd.mul_step == STEP_W'(0)) begin
            op_a = DP_W'(du1u_reg);
            op_b = du2v_reg;
        end else if (cmd.mul_step == STEP_W'(1)) begin
            op_a = DP_W'(du1v_reg);
            op_b = du2u_reg;
        end else begin
            case (sm2[1:0])
                2'd0:    begin op_a = dp1_sel; op_b = du2v_reg; end
                2'd1:    begin op_a = dp2_sel; op_b = du1v_reg; end
                2'd2:    begin op_a = dp2_sel; op_b = du1u_reg; end
                default: begin op_a = dp1_sel; op_b = du2u_reg; end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= PROD_W'(op_a) * PROD_W'(op_b);
        step_d_reg <= cmd.mul_step;
        if (pv_reg) begin
            if (!step_d_reg[0]) begin
                first_reg <= prod_reg;
            end else begin
                term_reg[step_d_reg[TERM_W:1]] <= NUM_W'(first_reg) - NUM_W'(prod_reg);
            end
        end
    end

    assign det = DET_W'(term_reg[0]);

    // divider set-up and one quotient bit per cycle in every lane
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dmag_reg     <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
            det_zero_reg <= (det == '0);
        end
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        logic [NUM_W-1:0] nmag;
        logic [HI_W-1:0]  hi;
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] dext;
        logic             ge;
        logic [QB:0]      rr;
        logic [QB-1:0]    mag;

        assign nmag = term_reg[j+1][NUM_W-1] ? NUM_W'(-term_reg[j+1])
                                             : NUM_W'(term_reg[j+1]);
        assign hi   = nmag[NUM_W-1:LO_W];
        assign dext = REM_W'(dmag_reg);
        assign t    = {rem_reg[j][REM_W-2:0], lo_reg[j][QB-1]};
        assign ge   = (t >= dext);

        always_ff @(posedge aclk) begin
            if (cmd.div_start) begin
                neg_reg[j] <= term_reg[j+1][NUM_W-1] ^ det[DET_W-1];
                ovf_reg[j] <= (REM_W'(hi) >=
                               REM_W'(det[DET_W-1] ? DET_W'(-det) : DET_W'(det)));
                rem_reg[j] <= REM_W'(hi);
                lo_reg[j]  <= {nmag[LO_W-1:0], {(UV_FRAC_BITS + 1){1'b0}}};
                q_reg[j]   <= '0;
            end else if (cmd.div_step) begin
                rem_reg[j] <= ge ? (t - dext) : t;
                lo_reg[j]  <= {lo_reg[j][QB-2:0], 1'b0};
                q_reg[j]   <= {q_reg[j][QB-2:0], ge};
            end
        end

        // round half away from zero on the magnitude, then saturate
        assign rr  = {1'b0, q_reg[j]} + (QB + 1)'(1);
        assign mag = rr[QB:1];

        always_comb begin
            if (det_zero_reg) begin
                res[j] = '0;
            end else if (neg_reg[j]) begin
                if (ovf_reg[j] || (mag > QB'(64'h8000_0000))) begin
                    res[j] = {1'b1, {(POS_W - 1){1'b0}}};
                end else begin
                    res[j] = -$signed(mag[POS_W-1:0]);
                end
            end else begin
                if (ovf_reg[j] || (mag > QB'(64'h7FFF_FFFF))) begin
                    res[j] = {1'b0, {(POS_W - 1){1'b1}}};
                end else begin
                    res[j] = $signed(mag[POS_W-1:0]);
                end
            end
        end
    end

    // result register and triangle counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tri_reg <= '0;
        end else if (cmd.out_load) begin
            tri_reg <= tri_reg + 1'b1;
        end
    end

    logic [TRI_W-1:0] tri_out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            for (int i = 0; i < 3; i++) begin
                bin_reg[i] <= res[2*i];
                tan_reg[i] <= res[2*i+1];
            end
            tri_out_reg <= tri_reg;
            degen_reg   <= det_zero_reg;
        end
    end

    assign m_tangent_x       = tan_reg[0];
    assign m_tangent_y       = tan_reg[1];
    assign m_tangent_z       = tan_reg[2];
    assign m_binormal_x      = bin_reg[0];
    assign m_binormal_y      = bin_reg[1];
    assign m_binormal_z      = bin_reg[2];
    assign m_triangle_number = tri_out_reg;
    assign m_degenerate      = degen_reg;

endmodule

@@ rtl/triangle_tangent_binormal.sv @@
// top level: per-triangle tangent and binormal from a stream of vertices
// first and second vertex of a triangle: stored in place
// third vertex: a multiply pass on the shared 33x20 multiplier, a set-up step, a pass through
// six bit-serial divider lanes and a load into the result register, which makes the beat valid
// no new vertex is taken until that load; a beat still waiting in the register stalls it
// reset (aresetn low, synchronous) clears the vertex slot, triangle count and valid
`timescale 1ns / 1ps
module triangle_tangent_binormal (
    input  logic                              aclk,
    input  logic                              aresetn,
    // vertex beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [tbn_pkg::POS_W-1:0]  s_pos_x,
    input  logic signed [tbn_pkg::POS_W-1:0]  s_pos_y,
    input  logic signed [tbn_pkg::POS_W-1:0]  s_pos_z,
    input  logic signed [tbn_pkg::UV_W-1:0]   s_tex_u,
    input  logic signed [tbn_pkg::UV_W-1:0]   s_tex_v,
    // result beats, one per triangle
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tbn_pkg::POS_W-1:0]  m_tangent_x,
    output logic signed [tbn_pkg::POS_W-1:0]  m_tangent_y,
    output logic signed [tbn_pkg::POS_W-1:0]  m_tangent_z,
    output logic signed [tbn_pkg::POS_W-1:0]  m_binormal_x,
    output logic signed [tbn_pkg::POS_W-1:0]  m_binormal_y,
    output logic signed [tbn_pkg::POS_W-1:0]  m_binormal_z,
    output logic        [tbn_pkg::TRI_W-1:0]  m_triangle_number,
    output logic                              m_degenerate
);
    import tbn_pkg::*;

    // command bundle from sequencer to datapath
    tbn_cmd_t cmd;

    // sequencer: vertex slot count and pass timing; vertices of the next
    // triangle are taken while the previous beat is still waiting
    tbn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // datapath: held vertices, deltas, products, quotients and result beat
    tbn_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .s_pos_x           (s_pos_x),
        .s_pos_y           (s_pos_y),
        .s_pos_z           (s_pos_z),
        .s_tex_u           (s_tex_u),
        .s_tex_v           (s_tex_v),
        .m_tangent_x       (m_tangent_x),
        .m_tangent_y       (m_tangent_y),
        .m_tangent_z       (m_tangent_z),
        .m_binormal_x      (m_binormal_x),
        .m_binormal_y      (m_binormal_y),
        .m_binormal_z      (m_binormal_z),
        .m_triangle_number (m_triangle_number),
        .m_degenerate      (m_degenerate)
    );

endmodule

@@ tb/sv/triangle_tangent_binormal_test.sv @@
// self-checking regression for the triangle tangent and binormal unit
`timescale 1ns / 1ps
module triangle_tangent_binormal_test;
    import tbn_pkg::*;

    // one result beat as the block should present it
    typedef struct {
        logic signed [POS_W-1:0] tan_x, tan_y, tan_z;
        logic signed [POS_W-1:0] bin_x, bin_y, bin_z;
        logic [TRI_W-1:0]        tri_num;
        logic                    degen;
    } tbn_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [POS_W-1:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [UV_W-1:0]  s_tex_u = '0, s_tex_v = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [POS_W-1:0] m_tangent_x, m_tangent_y, m_tangent_z;
    logic signed [POS_W-1:0] m_binormal_x, m_binormal_y, m_binormal_z;
    logic [TRI_W-1:0]        m_triangle_number;
    logic                    m_degenerate;

    triangle_tangent_binormal u_top (.*);

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the block's vertex store and counters
    longint      held_pos[2][3];
    longint      held_uv[2][2];
    int unsigned next_slot = 0;
    logic [TRI_W-1:0] tri_count = '0;

    tbn_result_t pending_tbn[$];
    int  mismatches = 0;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_req = 0;       // bumped by a test to ask for a long receiver stall
    int  hold_ack = 0;
    int  recv_hold = 0;      // long receiver stall, counted down by the receiver
    int  quiet_cycles = 0;

    // exact num * 2^UV_FRAC_BITS / den, magnitude rounded half away, then saturated
    function automatic logic signed [POS_W-1:0] scaled_quotient(longint num, longint den);
        logic [127:0] n, d, q, r;
        bit neg;
        neg = (num < 0) != (den < 0);
        n = 128'((num < 0) ? -num : num);
        d = 128'((den < 0) ? -den : den);
        n = n << UV_FRAC_BITS;
        q = n / d;
        r = n % d;
        if ((r << 1) >= d) q = q + 128'd1;
        if (neg) return (q > 128'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
        return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
    endfunction

    // absorb one accepted vertex; on the third one queue the triangle's result
    task automatic absorb_vertex(longint px, longint py, longint pz, longint tu, longint tv);
        longint p[3];
        longint dp1[3], dp2[3], du1[2], du2[2], det;
        logic signed [POS_W-1:0] tv3[3], bv3[3];
        tbn_result_t res;
        p[0] = px; p[1] = py; p[2] = pz;
        if (next_slot < 2) begin
            for (int i = 0; i < 3; i++) held_pos[next_slot][i] = p[i];
            held_uv[next_slot][0] = tu;
            held_uv[next_slot][1] = tv;
            next_slot++;
        end else begin
            for (int i = 0; i < 3; i++) begin
                dp1[i] = held_pos[1][i] - held_pos[0][i];
                dp2[i] = p[i] - held_pos[0][i];
            end
            du1[0] = held_uv[1][0] - held_uv[0][0];
            du1[1] = held_uv[1][1] - held_uv[0][1];
            du2[0] = tu - held_uv[0][0];
            du2[1] = tv - held_uv[0][1];
            det = du1[0] * du2[1] - du1[1] * du2[0];
            for (int i = 0; i < 3; i++) begin
                if (det == 0) begin
                    tv3[i] = '0;
                    bv3[i] = '0;
                end else begin
                    bv3[i] = scaled_quotient(dp1[i] * du2[1] - dp2[i] * du1[1], det);
                    tv3[i] = scaled_quotient(dp2[i] * du1[0] - dp1[i] * du2[0], det);
                end
            end
            res.tan_x = tv3[0]; res.tan_y = tv3[1]; res.tan_z = tv3[2];
            res.bin_x = bv3[0]; res.bin_y = bv3[1]; res.bin_z = bv3[2];
            res.tri_num = tri_count;
            res.degen = (det == 0);
            pending_tbn.insert(pending_tbn.size(), res);
            tri_count = tri_count + 1'b1;
            next_slot = 0;
        end
    endtask

    // inputs and outputs only move at the rising edge, so the falling edge sees
    // exactly what the next rising edge will take
    always @(negedge aclk) begin
        if (aresetn && s_valid && s_ready)
            absorb_vertex(s_pos_x, s_pos_y, s_pos_z, s_tex_u, s_tex_v);
    end

    // result checker: compare each beat with the oldest expectation
    always @(negedge aclk) begin
        tbn_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tbn.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat, triangle %0d", m_triangle_number);
            end else begin
                exp_r = pending_tbn.pop_front();
                if (m_tangent_x !== exp_r.tan_x || m_tangent_y !== exp_r.tan_y ||
                    m_tangent_z !== exp_r.tan_z || m_binormal_x !== exp_r.bin_x ||
                    m_binormal_y !== exp_r.bin_y || m_binormal_z !== exp_r.bin_z ||
                    m_triangle_number !== exp_r.tri_num || m_degenerate !== exp_r.degen) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch tri %0d: exp t=(%0d %0d %0d) b=(%0d %0d %0d) d=%0b",
                                 exp_r.tri_num, exp_r.tan_x, exp_r.tan_y, exp_r.tan_z,
                                 exp_r.bin_x, exp_r.bin_y, exp_r.bin_z, exp_r.degen);
                        $display("                 got t=(%0d %0d %0d) b=(%0d %0d %0d) d=%0b n=%0d",
                                 m_tangent_x, m_tangent_y, m_tangent_z, m_binormal_x,
                                 m_binormal_y, m_binormal_z, m_degenerate, m_triangle_number);
                    end
                end
            end
        end
    end

    // watchdog: too long without any beat moving on either side
    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles = 0;
        else if (++quiet_cycles >= 4000) begin
            $display("triangle_tangent_binormal regression: fail");
            $finish;
        end
    end

    // receiver: random idling, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            recv_hold <= 400;
            m_ready   <= 1'b0;
        end else if (recv_hold > 0) begin
            m_ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // send one vertex beat; called right after a rising edge, returns right
    // after the edge that accepted it with valid still high
    task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [18:0] tu, logic [18:0] tv);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= px;
        s_pos_y <= py;
        s_pos_z <= pz;
        s_tex_u <= tu;
        s_tex_v <= tv;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    // pick a position coordinate: mostly moderate, sometimes full range
    function automatic logic [31:0] rand_pos();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            default: return $signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
        endcase
    endfunction

    function automatic logic [18:0] rand_uv();
        case ($urandom_range(3))
            0:       return 19'($urandom);
            1:       return 19'($urandom_range(0, 63) - 32);
            default: return 19'($urandom_range(0, 19'h1FFFF));
        endcase
    endfunction

    task automatic send_triangle_random();
        logic [18:0] u0, v0, u1, v1;
        u0 = rand_uv(); v0 = rand_uv(); u1 = rand_uv(); v1 = rand_uv();
        send_vertex(rand_pos(), rand_pos(), rand_pos(), u0, v0);
        send_vertex(rand_pos(), rand_pos(), rand_pos(), u1, v1);
        case ($urandom_range(9))
            0:       send_vertex(rand_pos(), rand_pos(), rand_pos(), u0, v0);  // degenerate
            1:       send_vertex(rand_pos(), rand_pos(), rand_pos(), u1, v1);  // degenerate
            default: send_vertex(rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
        endcase
    endtask

    task automatic wait_drained();
        while (pending_tbn.size() != 0) @(posedge aclk);
    endtask

    // field extremes, degenerate uv, tiny determinant driving saturation
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // extreme positions, unit uv triangle
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 19'h0, 19'h0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 19'h10000, 19'h0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 19'h0, 19'h10000);
        // uv extremes
        send_vertex(32'h0001_0000, 32'h0, 32'h0, 19'h40000, 19'h3FFFF);
        send_vertex(32'h0, 32'h0001_0000, 32'h0, 19'h3FFFF, 19'h40000);
        send_vertex(32'h0, 32'h0, 32'h0001_0000, 19'h40000, 19'h40000);
        // degenerate: all uv equal
        send_vertex(32'h1234_5678, 32'h0, 32'h0, 19'h1234, 19'h5678);
        send_vertex(32'h0, 32'h1234_5678, 32'h0, 19'h1234, 19'h5678);
        send_vertex(32'h0, 32'h0, 32'h1234_5678, 19'h1234, 19'h5678);
        // degenerate: collinear uv
        send_vertex(32'h0, 32'h0, 32'h0, 19'h0, 19'h0);
        send_vertex(32'h0001_0000, 32'h0, 32'h0, 19'h100, 19'h200);
        send_vertex(32'h0, 32'h0001_0000, 32'h0, 19'h200, 19'h400);
        // determinant of one lsb squared: positive and negative saturation
        send_vertex(32'h0, 32'h0, 32'h0, 19'h0, 19'h0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 19'h1, 19'h0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 19'h0, 19'h1);
        // rounding and small quotients
        send_vertex(32'h0, 32'h0, 32'h0, 19'h0, 19'h0);
        send_vertex(32'h1, 32'h3, 32'hFFFF_FFFF, 19'h3, 19'h0);
        send_vertex(32'h2, 32'hFFFF_FFFD, 32'h5, 19'h0, 19'h2);
        // negative determinant
        send_vertex(32'h0, 32'h0, 32'h0, 19'h0, 19'h0);
        send_vertex(32'h0002_0000, 32'h0, 32'h0, 19'h0, 19'h8000);
        send_vertex(32'h0, 32'h0003_0000, 32'h0, 19'h8000, 19'h0);
        wait_drained();
    endtask

    task automatic test_random(int n_tri, int snd_pct, int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (n_tri) send_triangle_random();
    endtask

    // receiver stalls long enough for the block to fill up and block vertices
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
        repeat (6) send_triangle_random();
    endtask

    // sender pauses until every outstanding result has been collected
    task automatic test_drain_pause();
        send_idle_pct = 0;
        recv_idle_pct = 30;
        repeat (3) send_triangle_random();
        s_valid <= 1'b0;
        wait_drained();
        @(posedge aclk);
        repeat (3) send_triangle_random();
    endtask

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(180, 11, 81);
        test_random(180, 81, 11);
        test_random(180, 0, 0);

        s_valid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && pending_tbn.size() == 0)
            $display("triangle_tangent_binormal regression: pass");
        else
            $display("triangle_tangent_binormal regression: fail");
        $finish;
    end

endmodule

@@ triangle_tangent_binormal.f @@
rtl/tbn_pkg.sv
rtl/tbn_ctrl.sv
rtl/tbn_datapath.sv
rtl/triangle_tangent_binormal.sv
tb/sv/triangle_tangent_binormal_test.sv
